>>> rtl/map_run_length_decoder_macros.svh
// ----------------------------------------------------------------------------
// map run-length decoder assertion macros
// shared property shapes for the checker
// ----------------------------------------------------------------------------
`ifndef MAP_RUN_LENGTH_DECODER_MACROS_SVH
`define MAP_RUN_LENGTH_DECODER_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define MRLD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("mrld assertion failed");

// next-cycle implication, disabled while reset is active
`define MRLD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("mrld assertion failed");

`endif

>>> rtl/mrld_pkg.sv
// ----------------------------------------------------------------------------
// mrld_pkg
// types, constants and helper functions of the map run-length decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrld_pkg;

    // output field widths
    localparam int COLUMN_W = 12;
    localparam int ROW_W    = 12;
    localparam int VALUE_W  = 32;

    // command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // config port
    localparam int ADDR_W = 1;
    localparam logic [ADDR_W-1:0] REG_FLOAT_MODE = 1'b0;

    // special characters
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ESCAPE  = 8'h40;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;

    // front phase: run count, value, then six float digits
    typedef enum logic [2:0] {
        PH_COUNT,
        PH_VALUE,
        PH_DIG1,
        PH_DIG2,
        PH_DIG3,
        PH_DIG4,
        PH_DIG5,
        PH_DIG6
    } phase_t;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_NEWLINE,
        CMD_RUN,
        CMD_ERR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               fin;
        logic [5:0]         count;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    // bit 6 set: not in the alphabet
    function automatic logic [6:0] sym_decode(input logic [7:0] s);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (s >= CH_LOW_A && s <= CH_LOW_Z)
            begin
                d = s - CH_LOW_A;
            end
            else if (s >= CH_UP_A && s <= CH_UP_Z)
            begin
                d = s - CH_UP_A + 8'd26;
            end
            else if (s >= CH_ZERO && s <= CH_NINE)
            begin
                d = s - CH_ZERO + 8'd52;
            end
            else if (s == CH_UNDER)
            begin
                d = 8'd62;
            end
            else if (s == CH_DOLLAR)
            begin
                d = 8'd63;
            end
            else
            begin
                d = 8'h40;
            end
            return d[6:0];
        end
    endfunction

    // ieee single bits of a 6-bit integer
    function automatic logic [VALUE_W-1:0] small_int_float(input logic [5:0] v);
        logic [2:0]  p;
        logic [28:0] sh;
        logic [7:0]  expo;
        begin
            p = 3'd0;
            for (int i = 1; i < 6; i++)
            begin
                if (v[i])
                begin
                    p = 3'(i);
                end
            end
            sh   = 29'(v) << (5'd23 - 5'(p));
            expo = 8'd127 + 8'(p);
            if (v == 6'd0)
            begin
                return '0;
            end
            return {1'b0, expo, sh[22:0]};
        end
    endfunction

endpackage

>>> rtl/mrld_front.sv
// ----------------------------------------------------------------------------
// mrld_front
// takes symbols, tracks the pair / float-digit phase and queues commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrld_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          float_mode,
    input  logic          in_valid,
    input  logic [7:0]    symbol,
    input  logic          final_symbol,
    output logic          in_ready,
    input  logic          q_full,
    output logic          q_push,
    output mrld_pkg::cmd_t q_cmd
);

    mrld_pkg::phase_t phase_reg, phase_next;
    logic [5:0]       run_count_reg, run_count_next;
    logic [31:0]      float_bits_reg, float_bits_next;

    logic [6:0] dec;
    logic [5:0] v;
    logic       bad;
    logic       accept;
    logic       is_newline;
    logic       is_escape;
    logic [31:0] digit_bits;

    assign dec        = mrld_pkg::sym_decode(symbol);
    assign v          = dec[5:0];
    assign bad        = dec[6];
    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign is_newline = (phase_reg == mrld_pkg::PH_COUNT) && (symbol == mrld_pkg::CH_NEWLINE);
    assign is_escape  = (phase_reg == mrld_pkg::PH_VALUE) && float_mode
                        && (symbol == mrld_pkg::CH_ESCAPE);
    assign digit_bits = {float_bits_reg[25:0], v};

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        run_count_next  = run_count_reg;
        float_bits_next = float_bits_reg;
        if (accept)
        begin
            if (is_newline)
            begin
                phase_next = phase_reg;
            end
            else if (is_escape)
            begin
                float_bits_next = '0;
                phase_next      = mrld_pkg::PH_DIG1;
            end
            else if (bad)
            begin
                phase_next     = mrld_pkg::PH_COUNT;
                run_count_next = '0;
            end
            else
            begin
                case (phase_reg)
                    mrld_pkg::PH_COUNT:
                    begin
                        run_count_next = v;
                        phase_next     = mrld_pkg::PH_VALUE;
                    end
                    mrld_pkg::PH_VALUE:
                    begin
                        run_count_next = '0;
                        phase_next     = mrld_pkg::PH_COUNT;
                    end
                    mrld_pkg::PH_DIG6:
                    begin
                        float_bits_next = digit_bits;
                        run_count_next  = '0;
                        phase_next      = mrld_pkg::PH_COUNT;
                    end
                    default:
                    begin
                        float_bits_next = digit_bits;
                        phase_next      = mrld_pkg::phase_t'(phase_reg + 3'd1);
                    end
                endcase
            end
            if (final_symbol)
            begin
                phase_next      = mrld_pkg::PH_COUNT;
                run_count_next  = '0;
                float_bits_next = '0;
            end
        end
    end

    // queued command
    always_comb
    begin
        q_cmd.kind  = mrld_pkg::CMD_NOP;
        q_cmd.fin   = final_symbol;
        q_cmd.count = run_count_reg;
        q_cmd.value = '0;
        if (is_newline)
        begin
            q_cmd.kind = mrld_pkg::CMD_NEWLINE;
        end
        else if (is_escape)
        begin
            q_cmd.kind = mrld_pkg::CMD_NOP;
        end
        else if (bad)
        begin
            q_cmd.kind = mrld_pkg::CMD_ERR;
        end
        else
        begin
            case (phase_reg)
                mrld_pkg::PH_COUNT:
                begin
                    q_cmd.kind = mrld_pkg::CMD_NOP;
                end
                mrld_pkg::PH_VALUE:
                begin
                    if (run_count_reg != 6'd0)
                    begin
                        q_cmd.kind = mrld_pkg::CMD_RUN;
                    end
                    q_cmd.value = float_mode ? mrld_pkg::small_int_float(v) : 32'(v);
                end
                mrld_pkg::PH_DIG6:
                begin
                    if (run_count_reg != 6'd0)
                    begin
                        q_cmd.kind = mrld_pkg::CMD_RUN;
                    end
                    q_cmd.value = digit_bits;
                end
                default:
                begin
                    q_cmd.kind = mrld_pkg::CMD_NOP;
                end
            endcase
        end
        q_push = accept && ((q_cmd.kind != mrld_pkg::CMD_NOP) || final_symbol);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= mrld_pkg::PH_COUNT;
            run_count_reg  <= '0;
            float_bits_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            run_count_reg  <= run_count_next;
            float_bits_reg <= float_bits_next;
        end
    end

endmodule

>>> rtl/mrld_fifo.sv
// ----------------------------------------------------------------------------
// mrld_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrld_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mrld_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output mrld_pkg::cmd_t head_cmd,
    output logic           empty
);

    mrld_pkg::cmd_t entry_reg [mrld_pkg::QUEUE_DEPTH];

    logic [mrld_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mrld_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mrld_pkg::QPTR_W:0]   fill_reg, fill_next;
    logic                        do_push;
    logic                        do_pop;

    assign full     = (fill_reg == (mrld_pkg::QPTR_W + 1)'(mrld_pkg::QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

>>> rtl/mrld_back.sv
// ----------------------------------------------------------------------------
// mrld_back
// carries out queued commands, one cell per cycle into the output register while not stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrld_back #(
    parameter int COL_BITS = 12,
    parameter int ROW_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mrld_pkg::cmd_t                  head_cmd,
    input  logic                            q_empty,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mrld_pkg::COLUMN_W-1:0]   out_column,
    output logic [mrld_pkg::ROW_W-1:0]      out_row,
    output logic [mrld_pkg::VALUE_W-1:0]    out_value,
    output logic                            out_error,
    output logic                            out_last
);

    localparam logic [COL_BITS-1:0] COL_MAX = '1;

    logic                  act_valid_reg, act_valid_next;
    mrld_pkg::cmd_t        act_reg, act_next;
    logic [5:0]            rem_reg, rem_next;
    logic [COL_BITS-1:0]   col_reg, col_next;
    logic [ROW_BITS-1:0]   row_reg, row_next;
    logic                  over_reg, over_next;

    logic                           ov_reg, ov_next;
    logic [mrld_pkg::COLUMN_W-1:0]  ocol_reg, ocol_next;
    logic [mrld_pkg::ROW_W-1:0]     orow_reg, orow_next;
    logic [mrld_pkg::VALUE_W-1:0]   oval_reg, oval_next;
    logic                           oerr_reg, oerr_next;
    logic                           olast_reg, olast_next;

    logic                                  can_out;
    logic                                  finish;
    logic [COL_BITS-1:0]                   cell_col;
    logic [COL_BITS+mrld_pkg::COLUMN_W-1:0] col_wide;
    logic [ROW_BITS+mrld_pkg::ROW_W-1:0]    row_wide;

    assign can_out  = !ov_reg || out_ready;
    assign q_pop    = !act_valid_reg && !q_empty;
    assign cell_col = over_reg ? COL_MAX : col_reg;
    assign col_wide = {{mrld_pkg::COLUMN_W{1'b0}}, cell_col};
    assign row_wide = {{mrld_pkg::ROW_W{1'b0}}, row_reg};

    always_comb
    begin
        act_valid_next = act_valid_reg;
        act_next       = act_reg;
        rem_next       = rem_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        over_next      = over_reg;
        ov_next        = ov_reg;
        ocol_next      = ocol_reg;
        orow_next      = orow_reg;
        oval_next      = oval_reg;
        oerr_next      = oerr_reg;
        olast_next     = olast_reg;
        finish         = 1'b0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        if (q_pop)
        begin
            act_valid_next = 1'b1;
            act_next       = head_cmd;
            rem_next       = head_cmd.count;
        end
        else if (act_valid_reg)
        begin
            case (act_reg.kind)
                mrld_pkg::CMD_RUN:
                begin
                    if (can_out)
                    begin
                        ov_next    = 1'b1;
                        ocol_next  = col_wide[mrld_pkg::COLUMN_W-1:0];
                        orow_next  = row_wide[mrld_pkg::ROW_W-1:0];
                        oval_next  = act_reg.value;
                        oerr_next  = over_reg;
                        olast_next = (rem_reg == 6'd1);
                        if (col_reg == COL_MAX)
                        begin
                            over_next = 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                        rem_next = rem_reg - 6'd1;
                        finish   = (rem_reg == 6'd1);
                    end
                end
                mrld_pkg::CMD_ERR:
                begin
                    if (can_out)
                    begin
                        ov_next    = 1'b1;
                        ocol_next  = col_wide[mrld_pkg::COLUMN_W-1:0];
                        orow_next  = row_wide[mrld_pkg::ROW_W-1:0];
                        oval_next  = '0;
                        oerr_next  = 1'b1;
                        olast_next = 1'b1;
                        finish     = 1'b1;
                    end
                end
                mrld_pkg::CMD_NEWLINE:
                begin
                    row_next  = row_reg + 1'b1;
                    col_next  = '0;
                    over_next = 1'b0;
                    finish    = 1'b1;
                end
                default:
                begin
                    finish = 1'b1;
                end
            endcase

            if (finish)
            begin
                act_valid_next = 1'b0;
                if (act_reg.fin)
                begin
                    col_next  = '0;
                    row_next  = '0;
                    over_next = 1'b0;
                end
            end
        end
    end

    assign out_valid  = ov_reg;
    assign out_column = ocol_reg;
    assign out_row    = orow_reg;
    assign out_value  = oval_reg;
    assign out_error  = oerr_reg;
    assign out_last   = olast_reg;

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        rem_reg   <= rem_next;
        ocol_reg  <= ocol_next;
        orow_reg  <= orow_next;
        oval_reg  <= oval_next;
        oerr_reg  <= oerr_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            over_reg      <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            act_valid_reg <= act_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            over_reg      <= over_next;
            ov_reg        <= ov_next;
        end
    end

endmodule

>>> rtl/map_run_length_decoder.sv
// ----------------------------------------------------------------------------
// map_run_length_decoder
// decodes row-coded map text into one word per written cell
// ----------------------------------------------------------------------------
// usage:
//   - input stream: one map text character per word on s_tdata, s_tlast marks
//     the last character of a block (position and pair phase clear after it)
//   - output stream: one word per cell with column, row and value on m_tdata,
//     m_tuser flags a bad character or a column past its limit, m_tlast marks
//     the last cell caused by one input character
//   - apb register float_mode at address 0 selects float values and the '@'
//     escape; write it only while the block is idle
//   - a run's first cell passes the queue write, the command pop and the output
//     register, in that order, after its value character is taken
//   - throughput: characters that make no cell go in at one per cycle until
//     the 4-entry command queue fills; a run of n cells holds the back end for
//     a command pop, then one cell per cycle while m_tready does not stall
//   - reset clears the phase, the position, the queue and the output register
//   - a stalled m_tready holds the output word; the back end then stops, the
//     queue fills and s_tready drops
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module map_run_length_decoder #(
    parameter int COL_BITS = 12,
    parameter int ROW_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] symbol
    input  logic                          s_tlast,   // final_symbol
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [55:0]                   m_tdata,   // [11:0] column, [23:12] row,
                                                     // [55:24] cell_value
    output logic                          m_tuser,   // [0] error
    output logic                          m_tlast,   // last
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mrld_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic            float_mode_reg, float_mode_next;
    logic            cfg_wr;

    logic            q_push;
    mrld_pkg::cmd_t  q_cmd;
    logic            q_full;
    logic            q_pop;
    mrld_pkg::cmd_t  head_cmd;
    logic            q_empty;

    logic [mrld_pkg::COLUMN_W-1:0] out_column;
    logic [mrld_pkg::ROW_W-1:0]    out_row;
    logic [mrld_pkg::VALUE_W-1:0]  out_value;

    // apb: always ready, writes land in the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == mrld_pkg::REG_FLOAT_MODE);
    assign prdata = (paddr == mrld_pkg::REG_FLOAT_MODE) ? {31'b0, float_mode_reg} : 32'b0;

    always_comb
    begin
        float_mode_next = float_mode_reg;
        if (cfg_wr)
        begin
            float_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            float_mode_reg <= 1'b0;
        end
        else
        begin
            float_mode_reg <= float_mode_next;
        end
    end

    // front: character decode and pair / float-digit phase
    mrld_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .float_mode   (float_mode_reg),
        .in_valid     (s_tvalid),
        .symbol       (s_tdata),
        .final_symbol (s_tlast),
        .in_ready     (s_tready),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    // queue lets the front keep taking characters while a run expands
    mrld_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    // back: position tracking and cell expansion
    mrld_back #(
        .COL_BITS (COL_BITS),
        .ROW_BITS (ROW_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_column (out_column),
        .out_row    (out_row),
        .out_value  (out_value),
        .out_error  (m_tuser),
        .out_last   (m_tlast)
    );

    assign m_tdata = {out_value, out_row, out_column};

endmodule

>>> rtl/mrld_checker.sv
// ----------------------------------------------------------------------------
// mrld_checker
// port-level checks of the output stream, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "map_run_length_decoder_macros.svh"

module mrld_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // a stalled word holds
    `MRLD_ASSERT_NXT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // cells of one run follow back to back
    `MRLD_ASSERT_NXT(a_run_no_gap, clk, rst_n, m_tvalid && m_tready && !m_tlast, m_tvalid)

    // a run stays on one row
    `MRLD_ASSERT_NXT(a_run_same_row, clk, rst_n, m_tvalid && m_tready && !m_tlast, m_tdata[23:12] == $past(m_tdata[23:12]))

    // nothing shows right after reset
    `MRLD_ASSERT_IMP(a_reset_quiet, clk, rst_n, $rose(rst_n), !m_tvalid)

endmodule

bind map_run_length_decoder mrld_checker u_mrld_checker (.*);
